// File: hw/rtl/rig_frequency_reply_parser_defines.svh
// assertion helpers for the parser rtl
`ifndef RIG_FREQUENCY_REPLY_PARSER_DEFINES_SVH
`define RIG_FREQUENCY_REPLY_PARSER_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define RFRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define RFRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rfrp_pkg.sv
package rfrp_pkg;

  // field and datapath widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FREQ_W     = 50;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned TDATA_W    = 56;
  localparam int unsigned BCD_VAL_W  = 34;
  localparam int unsigned BODY_CNT_W = 4;

  // ascii digit limits
  localparam int unsigned MAX_ASCII_DIGITS_DEF = 15;
  localparam int unsigned MIN_ASCII_DIGITS     = 8;

  // binary frame bytes
  localparam logic [BYTE_W-1:0] BYTE_PREAMBLE = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_END      = 8'hFD;
  localparam logic [BYTE_W-1:0] CMD_READ_FREQ = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_BCAST_FREQ = 8'h00;

  // ascii reply characters
  localparam logic [BYTE_W-1:0] CHAR_F    = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;

  // body byte positions after the preamble
  localparam logic [BODY_CNT_W-1:0] BODY_CMD_POS   = 4'd2;
  localparam logic [BODY_CNT_W-1:0] BODY_DATA_POS  = 4'd3;
  localparam logic [BODY_CNT_W-1:0] BODY_FULL      = 4'd8;
  localparam logic [BODY_CNT_W-1:0] BODY_SAT       = 4'd15;

  localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;

  // reply kinds on tuser
  localparam logic [KIND_W-1:0] KIND_ASCII = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BCAST = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_MARK = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // control from the frame parser to the bcd accumulator
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [BYTE_W-1:0] data;
  } bcd_ctrl_t;

endpackage

// File: hw/rtl/rfrp_bcd_acc.sv
// running bcd decode, fed least significant byte first; an invalid nibble
// throws away everything below it, so the total matches a top-down decode
module rfrp_bcd_acc import rfrp_pkg::*; (
  input  logic                 clk,
  input  bcd_ctrl_t            ctrl,
  output logic [BCD_VAL_W-1:0] value
);

  logic [BCD_VAL_W-1:0] weight;
  logic [BCD_VAL_W-1:0] weight10;
  logic [BCD_VAL_W-1:0] value_next;
  logic [BCD_VAL_W-1:0] weight_next;
  logic [BCD_VAL_W-1:0] weight10_next;
  logic [3:0]           lo;
  logic [3:0]           hi;
  logic [BCD_VAL_W-1:0] lo_part;
  logic [BCD_VAL_W-1:0] hi_part;

  // two digits per byte, weights kept for both nibble positions
  always_comb begin
    lo            = ctrl.data[3:0];
    hi            = ctrl.data[7:4];
    lo_part       = BCD_VAL_W'(weight * BCD_VAL_W'(lo));
    hi_part       = BCD_VAL_W'(weight10 * BCD_VAL_W'(hi));
    value_next    = value;
    weight_next   = weight;
    weight10_next = weight10;
    if (ctrl.clear) begin
      value_next    = '0;
      weight_next   = BCD_VAL_W'(1);
      weight10_next = BCD_VAL_W'(10);
    end else if (ctrl.load) begin
      if (hi > BCD_DIGIT_MAX) begin
        value_next    = '0;
        weight_next   = BCD_VAL_W'(1);
        weight10_next = BCD_VAL_W'(10);
      end else if (lo > BCD_DIGIT_MAX) begin
        value_next    = BCD_VAL_W'(hi);
        weight_next   = BCD_VAL_W'(10);
        weight10_next = BCD_VAL_W'(100);
      end else begin
        value_next    = value + lo_part + hi_part;
        weight_next   = BCD_VAL_W'(weight * BCD_VAL_W'(100));
        weight10_next = BCD_VAL_W'(weight10 * BCD_VAL_W'(100));
      end
    end
  end

  always_ff @(posedge clk) begin
    value    <= value_next;
    weight   <= weight_next;
    weight10 <= weight10_next;
  end

endmodule

// File: hw/rtl/rig_frequency_reply_parser.sv
// channel   | direction | request carries
// ----------+-----------+------------------------------------------------
// s_axis    | in        | tdata[7:0] rx_byte
// m_axis    | out       | tdata[49:0] freq_hz, tuser[1:0] reply_kind
// cfg       | in        | cfg_data protocol_mode
//
// one byte per cycle; a reply appears in the cycle after its closing byte.
// the parser state and the bcd accumulator update in the accepting cycle,
// the output register holds a result while the next byte is taken.
// s_axis stalls only while a result waits on m_axis or a cfg write is offered.
// rst (synchronous) and every cfg write return the parser to the hunt phase.
`include "rig_frequency_reply_parser_defines.svh"

module rig_frequency_reply_parser import rfrp_pkg::*; #(
  parameter int unsigned MAX_ASCII_DIGITS = MAX_ASCII_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BYTE_W-1:0]  s_axis_tdata,   // rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // freq_hz, zero fill above
  output logic [KIND_W-1:0]  m_axis_tuser,   // reply_kind
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data        // protocol_mode
);

  localparam int unsigned CNT_W = $clog2(MAX_ASCII_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ASCII_DIGITS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_ASCII_DIGITS);

  logic                  protocol_mode;
  phase_t                phase;
  phase_t                phase_next;
  logic [BODY_CNT_W-1:0] body_count;
  logic [BODY_CNT_W-1:0] body_count_next;
  logic [BYTE_W-1:0]     command_byte;
  logic [BYTE_W-1:0]     command_byte_next;
  logic [FREQ_W-1:0]     acc;
  logic [FREQ_W-1:0]     acc_next;
  logic [CNT_W-1:0]      digit_count;
  logic [CNT_W-1:0]      digit_count_next;
  logic                  out_valid;
  logic [FREQ_W-1:0]     out_freq;
  logic [KIND_W-1:0]     out_kind;

  logic                  in_accept;
  logic                  cfg_accept;
  logic                  produced;
  logic [FREQ_W-1:0]     res_freq;
  logic [KIND_W-1:0]     res_kind;
  logic                  is_digit;
  logic [BYTE_W-1:0]     b;
  bcd_ctrl_t             bcd_ctrl;
  logic [BCD_VAL_W-1:0]  bcd_value;

  // handshakes
  assign cfg_ready     = 1'b1;
  assign cfg_accept    = cfg_valid && cfg_ready;
  assign s_axis_tready = (!out_valid || m_axis_tready) && !cfg_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign is_digit      = (b >= CHAR_0) && (b <= CHAR_9);

  rfrp_bcd_acc u_bcd_acc (
    .clk   (clk),
    .ctrl  (bcd_ctrl),
    .value (bcd_value)
  );

  // frame and reply parsing
  always_comb begin
    phase_next        = phase;
    body_count_next   = body_count;
    command_byte_next = command_byte;
    acc_next          = acc;
    digit_count_next  = digit_count;
    bcd_ctrl          = '0;
    bcd_ctrl.data     = b;
    produced          = 1'b0;
    res_freq          = '0;
    res_kind          = KIND_ASCII;
    if (cfg_accept) begin
      phase_next        = PH_HUNT;
      body_count_next   = '0;
      command_byte_next = '0;
      acc_next          = '0;
      digit_count_next  = '0;
      bcd_ctrl.clear    = 1'b1;
    end else if (in_accept && !protocol_mode) begin
      case (phase)
        PH_HUNT: begin
          if (b == BYTE_PREAMBLE) phase_next = PH_MARK;
        end
        PH_MARK: begin
          if (b == BYTE_PREAMBLE) begin
            phase_next        = PH_BODY;
            body_count_next   = '0;
            command_byte_next = '0;
            bcd_ctrl.clear    = 1'b1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (b == BYTE_END) begin
            if (body_count == BODY_FULL &&
                (command_byte == CMD_READ_FREQ || command_byte == CMD_BCAST_FREQ)) begin
              produced = 1'b1;
              res_freq = FREQ_W'(bcd_value);
              res_kind = (command_byte == CMD_READ_FREQ) ? KIND_READ : KIND_BCAST;
            end
            phase_next = PH_HUNT;
          end else begin
            if (body_count == BODY_CMD_POS) begin
              command_byte_next = b;
            end else if (body_count >= BODY_DATA_POS && body_count < BODY_FULL) begin
              bcd_ctrl.load = 1'b1;
            end
            if (body_count < BODY_SAT) body_count_next = body_count + 1'b1;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end else if (in_accept) begin
      case (phase)
        PH_HUNT: begin
          if (b == CHAR_F) phase_next = PH_MARK;
        end
        PH_MARK: begin
          if (b == CHAR_A) begin
            phase_next       = PH_BODY;
            acc_next         = '0;
            digit_count_next = '0;
          end else if (b != CHAR_F) begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (b == CHAR_SEMI) begin
            if (digit_count >= CNT_MIN) begin
              produced = 1'b1;
              res_freq = acc;
              res_kind = KIND_ASCII;
            end
            phase_next = PH_HUNT;
          end else if (is_digit && digit_count < CNT_MAX) begin
            acc_next         = (acc << 3) + (acc << 1) + FREQ_W'(b[3:0]);
            digit_count_next = digit_count + 1'b1;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_mode <= 1'b0;
      phase         <= PH_HUNT;
      body_count    <= '0;
      command_byte  <= '0;
      digit_count   <= '0;
    end else begin
      if (cfg_accept) protocol_mode <= cfg_data;
      phase        <= phase_next;
      body_count   <= body_count_next;
      command_byte <= command_byte_next;
      digit_count  <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= produced;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && produced) begin
      out_freq <= res_freq;
      out_kind <= res_kind;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'(out_freq);
  assign m_axis_tuser  = out_kind;

  // checks
  `RFRP_ASSERT_NEXT(a_cfg_restart, cfg_accept, phase == PH_HUNT && digit_count == '0 && body_count == '0, "cfg write did not restart the parser")
  `RFRP_ASSERT_NOW(a_result_from_byte, $rose(out_valid), $past(in_accept), "result appeared without an accepted byte")
  `RFRP_ASSERT_NOW(a_digit_bound, 1'b1, digit_count <= CNT_MAX, "ascii digit count above its limit")

endmodule
